/* hw/rtl/tyarr_pkg.sv */
package tyarr_pkg;

  // Register indexes of the configuration port.
  typedef enum logic [1:0] {
    REG_TILT_GAIN = 2'd0,
    REG_YAW_GAIN  = 2'd1
  } cfg_reg_e;

  localparam logic [15:0] TILT_GAIN_RST = 16'd24576;
  localparam logic [15:0] YAW_GAIN_RST  = 16'd12288;

  // CORDIC geometry: angles in units of 2^-30 rad.
  localparam int CORDIC_STEPS = 32;
  localparam int CORDIC_LAT   = CORDIC_STEPS + 2;
  localparam int CORDIC_W     = 36;
  localparam int ANG_W        = 34;

  // Divider: 32 quotient bits, one per stage.
  localparam int DIV_LAT = 32;

  // Square root: 31 result bits, one per stage.
  localparam int SQRT_STEPS = 31;

  // atan(2^-i) in units of 2^-30 rad.
  localparam logic [31:0] ATAN_TAB [CORDIC_STEPS] = '{
    32'd843314856, 32'd497837829, 32'd263043836, 32'd133525158, 32'd67021686,
    32'd33543515, 32'd16777898, 32'd8388437, 32'd4194282, 32'd2097149,
    32'd1048575, 32'd524287, 32'd262143, 32'd131071, 32'd65535, 32'd32767,
    32'd16383, 32'd8191, 32'd4095, 32'd2047, 32'd1023, 32'd511, 32'd255,
    32'd127, 32'd63, 32'd31, 32'd15, 32'd8, 32'd4, 32'd2, 32'd1, 32'd0
  };

  // Index of the highest set bit; zero for a zero word.
  function automatic logic [5:0] msb64(input logic [63:0] v);
    logic [5:0] r;
    r = '0;
    for (int i = 0; i < 64; i++) begin
      if (v[i]) begin
        r = 6'(i);
      end
    end
    return r;
  endfunction

endpackage

/* hw/rtl/tilt_yaw_attitude_rate_reference_top.sv */
// Tilt-prioritized attitude to body-rate reference. Each input transaction
// carries a body quaternion, a target quaternion (both Q2.30) and a
// feedforward rate (Q8.16); the block forms the error quaternion, splits it
// into a tilt rotation and a yaw twist, and returns
// tilt_gain * tilt + yaw_gain * yaw + feedforward, rounded to Q8.16,
// saturated per axis, with tuser set when any axis saturated. The datapath
// is a 112-stage pipeline that takes one transaction every cycle while it
// is not held; the whole pipeline holds while the output result is not
// taken. Its depth is set by the 31-stage square root, the 34-stage CORDIC
// and the 32-stage dividers. Gains are written through the configuration
// channel (index 0 tilt gain, index 1 yaw gain, unsigned Q4.12); the user
// must write them only while no transaction is in flight, which the block
// does not enforce. Other indexes are ignored.
module tilt_yaw_attitude_rate_reference_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // body_w, body_x, body_y, body_z, target_w, target_x, target_y, target_z,
  // feedforward_x, feedforward_y, feedforward_z
  input  logic [327:0]  s_axis_tdata,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // rate_x, rate_y, rate_z
  output logic [71:0]   m_axis_tdata,
  // clipped
  output logic          m_axis_tuser,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [1:0]    cfg_index_i,
  input  logic [15:0]   cfg_data_i
);
  import tyarr_pkg::*;

  localparam int PRE_LAT = 10;
  localparam int LAT = PRE_LAT + SQRT_STEPS + CORDIC_LAT + 2 + DIV_LAT + 3;

  typedef struct packed {
    logic signed [31:0] a;
    logic signed [31:0] b;
    logic signed [31:0] c;
    logic signed [31:0] w;
    logic signed [31:0] z;
    logic [71:0]        ff;
  } sq_side_t;

  typedef struct packed {
    logic signed [31:0] b;
    logic signed [31:0] c;
    logic [30:0]        s;
    logic [71:0]        ff;
  } cs_side_t;

  typedef struct packed {
    logic               sb;
    logic               sc;
    logic               sz;
    logic signed [34:0] yz;
    logic [71:0]        ff;
  } dv_side_t;

  logic             adv;
  logic [LAT-1:0]   vld_q;
  logic [15:0]      tilt_gain_q;
  logic [15:0]      yaw_gain_q;

  // Stage 1..10 signals.
  logic signed [32:0] cv [4];
  logic signed [32:0] rv [4];
  logic signed [65:0] prod;
  logic signed [63:0] pr_d [16];
  logic signed [63:0] pr_q [16];
  logic [71:0]        ffe_q [PRE_LAT-1];
  logic signed [63:0] sum_q [4];
  logic signed [31:0] ew, ex, ey, ez;
  logic signed [31:0] w3_q, x3_q, y3_q, z3_q;
  logic signed [63:0] ww4_q, zz4_q, wx4_q, yz4_q, wy4_q, xz4_q;
  logic signed [31:0] x4_q, y4_q, w4_q, z4_q;
  logic               sing4_q;
  logic signed [63:0] a5_q, b5_q, c5_q;
  logic signed [31:0] w5_q, z5_q;
  logic signed [63:0] ab6, ac6;
  logic [63:0]        or6_q;
  logic signed [63:0] a6_q, b6_q, c6_q;
  logic signed [31:0] w6_q, z6_q;
  logic [5:0]         msb7;
  logic [5:0]         k7_q;
  logic signed [63:0] a7_q, b7_q, c7_q;
  logic signed [31:0] w7_q, z7_q;
  logic signed [31:0] a8_q, b8_q, c8_q, w8_q, z8_q;
  logic signed [63:0] bb9_q, cc9_q;
  logic signed [31:0] a9_q, b9_q, c9_q, w9_q, z9_q;
  logic [61:0]        rad10_q;
  sq_side_t           side10_q;

  // Square root section.
  logic [32:0]        sq_rem_q  [SQRT_STEPS];
  logic [30:0]        sq_root_q [SQRT_STEPS];
  logic [61:0]        sq_rad_q  [SQRT_STEPS];
  sq_side_t           sqs_q     [SQRT_STEPS];
  sq_side_t           sq_out;
  logic [30:0]        s41;

  // CORDIC section.
  logic signed [ANG_W-1:0] ang_tilt;
  logic signed [ANG_W-1:0] ang_yaw;
  cs_side_t                cs_q [CORDIC_LAT];
  cs_side_t                cs_out;

  // Tilt scaling and division.
  logic signed [34:0]  th;
  logic signed [66:0]  nb76_q, nc76_q;
  logic [30:0]         s76_q;
  logic signed [34:0]  yz76_q;
  logic [71:0]         ff76_q;
  logic [62:0]         nbm77_q, ncm77_q;
  logic                nbs77_q, ncs77_q;
  logic [30:0]         s77_q;
  logic signed [34:0]  yz77_q;
  logic [71:0]         ff77_q;
  logic [31:0]         qb, qc;
  dv_side_t            dv_q [DIV_LAT];
  dv_side_t            dv_out;
  logic signed [32:0]  lx110_q, ly110_q;
  logic signed [34:0]  yz110_q;
  logic [71:0]         ff110_q;
  logic signed [49:0]  gx111_q, gy111_q;
  logic signed [51:0]  gz111_q;
  logic [71:0]         ff111_q;
  logic [24:0]         fx, fy, fz;
  logic [71:0]         out_q;
  logic                clip_q;

  // Rounds a Q-42 sum to Q8.16 and clamps it; bit 24 flags saturation.
  function automatic logic [24:0] finish(input logic signed [55:0] g,
                                         input logic signed [23:0] ff);
    logic signed [55:0] t;
    logic signed [29:0] v;
    logic [24:0]        r;
    t = g + (56'(ff) <<< 26) + 56'(33554432);
    v = 30'(t >>> 26);
    if (v > 30'sd8388607) begin
      r = {1'b1, 24'h7FFFFF};
    end else if (v < -30'sd8388608) begin
      r = {1'b1, 24'h800000};
    end else begin
      r = {1'b0, v[23:0]};
    end
    return r;
  endfunction

  // The pipeline moves whenever the output register can take a result.
  assign adv           = !vld_q[LAT-1] || m_axis_tready;
  assign s_axis_tready = adv;
  assign m_axis_tvalid = vld_q[LAT-1];
  assign m_axis_tdata  = out_q;
  assign m_axis_tuser  = clip_q;
  assign cfg_ready_o   = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[LAT-2:0], s_axis_tvalid};
    end
  end

  // Gain registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tilt_gain_q <= TILT_GAIN_RST;
      yaw_gain_q  <= YAW_GAIN_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_TILT_GAIN: tilt_gain_q <= cfg_data_i;
        REG_YAW_GAIN:  yaw_gain_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Stage 1: the sixteen products of conj(body) * target, each floor-scaled.
  always_comb begin
    cv[0] = 33'($signed(s_axis_tdata[31:0]));
    cv[1] = -33'($signed(s_axis_tdata[63:32]));
    cv[2] = -33'($signed(s_axis_tdata[95:64]));
    cv[3] = -33'($signed(s_axis_tdata[127:96]));
    rv[0] = 33'($signed(s_axis_tdata[159:128]));
    rv[1] = 33'($signed(s_axis_tdata[191:160]));
    rv[2] = 33'($signed(s_axis_tdata[223:192]));
    rv[3] = 33'($signed(s_axis_tdata[255:224]));
    prod  = '0;
    for (int ci = 0; ci < 4; ci++) begin
      for (int ri = 0; ri < 4; ri++) begin
        prod = cv[ci] * rv[ri];
        pr_d[ci*4+ri] = 64'(prod >>> 2);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pr_q     <= pr_d;
      ffe_q[0] <= s_axis_tdata[327:256];
      for (int i = 1; i < PRE_LAT - 1; i++) begin
        ffe_q[i] <= ffe_q[i-1];
      end
    end
  end

  // Stage 2: Hamilton product sums.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      sum_q[0] <= pr_q[0] - pr_q[5] - pr_q[10] - pr_q[15];
      sum_q[1] <= pr_q[1] + pr_q[4] + pr_q[11] - pr_q[14];
      sum_q[2] <= pr_q[2] - pr_q[7] + pr_q[8] + pr_q[13];
      sum_q[3] <= pr_q[3] + pr_q[6] - pr_q[9] + pr_q[12];
    end
  end

  // Stage 3: scale to 2^-26 and keep the scalar part non-negative.
  always_comb begin
    ew = sum_q[0][63:32];
    ex = sum_q[1][63:32];
    ey = sum_q[2][63:32];
    ez = sum_q[3][63:32];
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (ew < 0) begin
        w3_q <= -ew;
        x3_q <= -ex;
        y3_q <= -ey;
        z3_q <= -ez;
      end else begin
        w3_q <= ew;
        x3_q <= ex;
        y3_q <= ey;
        z3_q <= ez;
      end
    end
  end

  // Stage 4: products for the tilt direction.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      ww4_q   <= w3_q * w3_q;
      zz4_q   <= z3_q * z3_q;
      wx4_q   <= w3_q * x3_q;
      yz4_q   <= y3_q * z3_q;
      wy4_q   <= w3_q * y3_q;
      xz4_q   <= x3_q * z3_q;
      sing4_q <= (w3_q == 0) && (z3_q == 0);
      x4_q    <= x3_q;
      y4_q    <= y3_q;
      w4_q    <= w3_q;
      z4_q    <= z3_q;
    end
  end

  // Stage 5: tilt direction; in the tilt singularity all error is tilt.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (sing4_q) begin
        a5_q <= '0;
        b5_q <= 64'(x4_q);
        c5_q <= 64'(y4_q);
      end else begin
        a5_q <= ww4_q + zz4_q;
        b5_q <= wx4_q - yz4_q;
        c5_q <= wy4_q + xz4_q;
      end
      w5_q <= w4_q;
      z5_q <= z4_q;
    end
  end

  // Stage 6: magnitude envelope of the direction.
  always_comb begin
    ab6 = (b5_q < 0) ? -b5_q : b5_q;
    ac6 = (c5_q < 0) ? -c5_q : c5_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      or6_q <= a5_q | ab6 | ac6;
      a6_q  <= a5_q;
      b6_q  <= b5_q;
      c6_q  <= c5_q;
      w6_q  <= w5_q;
      z6_q  <= z5_q;
    end
  end

  // Stage 7: shift that brings the largest component below 2^30.
  assign msb7 = msb64(or6_q);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      k7_q <= (msb7 >= 6'd30) ? 6'(msb7 - 6'd29) : 6'd0;
      a7_q <= a6_q;
      b7_q <= b6_q;
      c7_q <= c6_q;
      w7_q <= w6_q;
      z7_q <= z6_q;
    end
  end

  // Stage 8: apply the reduction shift.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      a8_q <= 32'(a7_q >>> k7_q);
      b8_q <= 32'(b7_q >>> k7_q);
      c8_q <= 32'(c7_q >>> k7_q);
      w8_q <= w7_q;
      z8_q <= z7_q;
    end
  end

  // Stages 9 and 10: radicand b*b + c*c.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      bb9_q <= b8_q * b8_q;
      cc9_q <= c8_q * c8_q;
      a9_q  <= a8_q;
      b9_q  <= b8_q;
      c9_q  <= c8_q;
      w9_q  <= w8_q;
      z9_q  <= z8_q;
      rad10_q     <= 62'(bb9_q + cc9_q);
      side10_q.a  <= a9_q;
      side10_q.b  <= b9_q;
      side10_q.c  <= c9_q;
      side10_q.w  <= w9_q;
      side10_q.z  <= z9_q;
      side10_q.ff <= ffe_q[PRE_LAT-2];
    end
  end

  // Square root, one result bit per stage.
  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
    logic [32:0] rp;
    logic [30:0] qp;
    logic [61:0] dp;
    sq_side_t    sp;
    logic [34:0] r2;
    logic [34:0] t;
    logic        ge;

    if (j == 0) begin : g_first
      assign rp = '0;
      assign qp = '0;
      assign dp = rad10_q;
      assign sp = side10_q;
    end else begin : g_next
      assign rp = sq_rem_q[j-1];
      assign qp = sq_root_q[j-1];
      assign dp = sq_rad_q[j-1];
      assign sp = sqs_q[j-1];
    end

    assign r2 = {rp, dp[2*(SQRT_STEPS-1-j)+1 -: 2]};
    assign t  = {2'b00, qp, 2'b01};
    assign ge = (r2 >= t);

    always_ff @(posedge clk_i) begin
      if (adv) begin
        sq_rem_q[j]  <= ge ? 33'(r2 - t) : r2[32:0];
        sq_root_q[j] <= {qp[29:0], ge};
        sq_rad_q[j]  <= dp;
        sqs_q[j]     <= sp;
      end
    end
  end

  assign sq_out = sqs_q[SQRT_STEPS-1];
  assign s41    = sq_root_q[SQRT_STEPS-1];

  // Tilt angle atan2(s, a) and yaw angle atan2(z, w), side by side.
  tyarr_cordic u_cordic_tilt (
    .clk_i (clk_i),
    .en_i  (adv),
    .x_i   (sq_out.a),
    .y_i   ($signed({1'b0, s41})),
    .ang_o (ang_tilt)
  );

  tyarr_cordic u_cordic_yaw (
    .clk_i (clk_i),
    .en_i  (adv),
    .x_i   (sq_out.w),
    .y_i   (sq_out.z),
    .ang_o (ang_yaw)
  );

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cs_q[0].b  <= sq_out.b;
      cs_q[0].c  <= sq_out.c;
      cs_q[0].s  <= s41;
      cs_q[0].ff <= sq_out.ff;
      for (int i = 1; i < CORDIC_LAT; i++) begin
        cs_q[i] <= cs_q[i-1];
      end
    end
  end

  assign cs_out = cs_q[CORDIC_LAT-1];
  assign th     = 35'(ang_tilt) <<< 1;

  // Scale the tilt direction by the doubled angle.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      nb76_q <= th * cs_out.b;
      nc76_q <= th * cs_out.c;
      s76_q  <= cs_out.s;
      yz76_q <= 35'(ang_yaw) <<< 1;
      ff76_q <= cs_out.ff;
    end
  end

  // Split into sign and magnitude for the dividers.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      nbm77_q <= 63'((nb76_q < 0) ? -nb76_q : nb76_q);
      ncm77_q <= 63'((nc76_q < 0) ? -nc76_q : nc76_q);
      nbs77_q <= nb76_q < 0;
      ncs77_q <= nc76_q < 0;
      s77_q   <= s76_q;
      yz77_q  <= yz76_q;
      ff77_q  <= ff76_q;
    end
  end

  tyarr_div u_div_x (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i (nbm77_q),
    .den_i (s77_q),
    .quo_o (qb)
  );

  tyarr_div u_div_y (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i (ncm77_q),
    .den_i (s77_q),
    .quo_o (qc)
  );

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dv_q[0].sb <= nbs77_q;
      dv_q[0].sc <= ncs77_q;
      dv_q[0].sz <= (s77_q == '0);
      dv_q[0].yz <= yz77_q;
      dv_q[0].ff <= ff77_q;
      for (int i = 1; i < DIV_LAT; i++) begin
        dv_q[i] <= dv_q[i-1];
      end
    end
  end

  assign dv_out = dv_q[DIV_LAT-1];

  // Restore signs; a zero tilt vector gives no tilt rate.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (dv_out.sz) begin
        lx110_q <= '0;
        ly110_q <= '0;
      end else begin
        lx110_q <= dv_out.sb ? -$signed({1'b0, qb}) : $signed({1'b0, qb});
        ly110_q <= dv_out.sc ? -$signed({1'b0, qc}) : $signed({1'b0, qc});
      end
      yz110_q <= dv_out.yz;
      ff110_q <= dv_out.ff;
    end
  end

  // Gain products.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      gx111_q <= $signed({1'b0, tilt_gain_q}) * lx110_q;
      gy111_q <= $signed({1'b0, tilt_gain_q}) * ly110_q;
      gz111_q <= $signed({1'b0, yaw_gain_q}) * yz110_q;
      ff111_q <= ff110_q;
    end
  end

  // Feedforward, rounding and saturation into the output register.
  always_comb begin
    fx = finish(56'(gx111_q), $signed(ff111_q[23:0]));
    fy = finish(56'(gy111_q), $signed(ff111_q[47:24]));
    fz = finish(56'(gz111_q), $signed(ff111_q[71:48]));
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q  <= {fz[23:0], fy[23:0], fx[23:0]};
      clip_q <= fx[24] | fy[24] | fz[24];
    end
  end

`ifndef SYNTH
  // A held result must stall the input side.
  a_stall_reaches_input : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input accepted while output result is held");

  // A flagged result has at least one axis at a rail.
  a_clip_at_rail : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |->
      (m_axis_tdata[23:0] == 24'h7FFFFF) || (m_axis_tdata[23:0] == 24'h800000) ||
      (m_axis_tdata[47:24] == 24'h7FFFFF) || (m_axis_tdata[47:24] == 24'h800000) ||
      (m_axis_tdata[71:48] == 24'h7FFFFF) || (m_axis_tdata[71:48] == 24'h800000))
    else $error("saturation flag without a saturated axis");

  // A tilt gain write lands in the gain register.
  a_tilt_gain_write : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i && (cfg_index_i == REG_TILT_GAIN) |=> tilt_gain_q == $past(cfg_data_i))
    else $error("tilt gain write lost");
`endif

endmodule

/* hw/rtl/tyarr_cordic.sv */
module tyarr_cordic (
  input  logic                               clk_i,
  input  logic                               en_i,
  input  logic signed [31:0]                 x_i,
  input  logic signed [31:0]                 y_i,
  output logic signed [tyarr_pkg::ANG_W-1:0] ang_o
);
  import tyarr_pkg::*;

  logic signed [32:0]          yabs;
  logic [32:0]                 orv;
  logic [5:0]                  msb;
  logic [4:0]                  nsh;
  logic [4:0]                  n_q;
  logic signed [31:0]          x0_q;
  logic signed [31:0]          y0_q;
  logic                        z0_q;
  logic signed [CORDIC_W-1:0]  cx_q [CORDIC_STEPS+1];
  logic signed [CORDIC_W-1:0]  cy_q [CORDIC_STEPS+1];
  logic signed [ANG_W-1:0]     ca_q [CORDIC_STEPS+1];
  logic                        cz_q [CORDIC_STEPS+1];

  // Prescale: find the shift that brings the larger input up to 2^30.
  always_comb begin
    yabs = (y_i < 0) ? -33'(y_i) : 33'(y_i);
    orv  = {1'b0, x_i} | yabs;
    msb  = msb64(64'(orv));
    nsh  = (orv >= (33'd1 << 30)) ? 5'd0 : 5'(6'd30 - msb);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n_q  <= nsh;
      x0_q <= x_i;
      y0_q <= y_i;
      z0_q <= (y_i == 0);
    end
  end

  // Apply the prescale shift.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cx_q[0] <= CORDIC_W'(x0_q) <<< n_q;
      cy_q[0] <= CORDIC_W'(y0_q) <<< n_q;
      ca_q[0] <= '0;
      cz_q[0] <= z0_q;
    end
  end

  // One vectoring micro-rotation per stage.
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        cz_q[i+1] <= cz_q[i];
        if (cy_q[i] >= 0) begin
          cx_q[i+1] <= cx_q[i] + (cy_q[i] >>> i);
          cy_q[i+1] <= cy_q[i] - (cx_q[i] >>> i);
          ca_q[i+1] <= ca_q[i] + $signed({2'b00, ATAN_TAB[i]});
        end else begin
          cx_q[i+1] <= cx_q[i] - (cy_q[i] >>> i);
          cy_q[i+1] <= cy_q[i] + (cx_q[i] >>> i);
          ca_q[i+1] <= ca_q[i] - $signed({2'b00, ATAN_TAB[i]});
        end
      end
    end
  end

  // A zero vector part has zero angle.
  assign ang_o = cz_q[CORDIC_STEPS] ? '0 : ca_q[CORDIC_STEPS];

endmodule

/* hw/rtl/tyarr_div.sv */
module tyarr_div (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [62:0] num_i,
  input  logic [30:0] den_i,
  output logic [31:0] quo_o
);
  import tyarr_pkg::*;

  logic [30:0] rem_q [DIV_LAT];
  logic [31:0] lo_q  [DIV_LAT];
  logic [30:0] den_q [DIV_LAT];
  logic [31:0] quo_q [DIV_LAT];

  // Restoring division; the quotient is known to fit in 32 bits, so the
  // upper half of the numerator is already a valid partial remainder.
  for (genvar j = 0; j < DIV_LAT; j++) begin : g_step
    logic [30:0] rp;
    logic [31:0] lp;
    logic [30:0] dp;
    logic [31:0] qp;
    logic [31:0] r2;
    logic        ge;

    if (j == 0) begin : g_first
      assign rp = num_i[62:32];
      assign lp = num_i[31:0];
      assign dp = den_i;
      assign qp = '0;
    end else begin : g_next
      assign rp = rem_q[j-1];
      assign lp = lo_q[j-1];
      assign dp = den_q[j-1];
      assign qp = quo_q[j-1];
    end

    assign r2 = {rp, lp[DIV_LAT-1-j]};
    assign ge = (r2 >= {1'b0, dp});

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j] <= ge ? 31'(r2 - {1'b0, dp}) : r2[30:0];
        lo_q[j]  <= lp;
        den_q[j] <= dp;
        quo_q[j] <= {qp[30:0], ge};
      end
    end
  end

  assign quo_o = quo_q[DIV_LAT-1];

endmodule
